[hdl/batp_pkg.sv]
// battery-aware transmit policy: shared types, constants and helper functions
// no dependencies; imported by every module of the block
package batp_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int BUF_W       = $clog2(STORE_DEPTH + 1);

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_CHECK  = 2'd1;
    localparam logic [1:0] MODE_DONE   = 2'd2;

    localparam logic [1:0] LVL_FULL = 2'd0;
    localparam logic [1:0] LVL_MID  = 2'd1;
    localparam logic [1:0] LVL_LOW  = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LEVEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_LIM  = 3'd4;

    localparam logic [31:0] DAY_MINUTES    = 32'd1440;
    localparam logic [33:0] BASELINE_SENDS = 34'd144;

    // floor(x/3) = (x * 43691) >> 17 for x below 2^17
    localparam logic [31:0] DIV3_MUL   = 32'd43691;
    localparam int          DIV3_SHIFT = 17;
    // floor(n*100/144) = floor(n*25/36) = (n * 25 * 3641) >> 17
    localparam logic [23:0] SAV_MUL    = 24'd91025;
    localparam int          SAV_SHIFT  = 17;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        time_now;
        logic [12:0]        battery_mv;
        logic signed [23:0] sensor_reading;
        logic               force_req;
    } t_in;

    typedef struct packed {
        logic [1:0]  power_level;
        logic        transmit;
        logic        flush_request;
        logic        store_write;
        logic [7:0]  store_slot;
        logic [12:0] filtered_mv;
        logic [6:0]  savings_percent;
    } t_out;

    typedef struct packed {
        logic [12:0] full_level_mv;
        logic [12:0] mid_level_mv;
        logic [15:0] full_period_min;
        logic [15:0] mid_period_min;
        logic [15:0] change_limit_q10;
    } t_cfg;

    // level tracker status seen by the policy
    typedef struct packed {
        logic [1:0]  level;
        logic [31:0] low_entry_time;
    } t_lvl_stat;

    // level tracker contribution to one result
    typedef struct packed {
        logic [1:0]  level;
        logic        flush_request;
        logic [12:0] filtered_mv;
    } t_lvl_res;

    // policy contribution to one result
    typedef struct packed {
        logic       transmit;
        logic       store_write;
        logic [7:0] store_slot;
    } t_pol_res;

    function automatic logic [12:0] div3(input logic [14:0] sum);
        logic [31:0] prod;
        prod = 32'(sum) * DIV3_MUL;
        return 13'(prod >> DIV3_SHIFT);
    endfunction

    function automatic logic [6:0] savings_pct(input logic [33:0] total);
        logic [7:0]  n;
        logic [23:0] prod;
        n    = 8'(BASELINE_SENDS - total);
        prod = 24'(n) * SAV_MUL;
        if (total < BASELINE_SENDS) begin
            return 7'(prod >> SAV_SHIFT);
        end
        return 7'd0;
    endfunction

endpackage

[hdl/batp_regs.sv]
// configuration register file of the transmit policy
// depends on batp_pkg for the register layout and index codes
module batp_regs import batp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [15:0]          i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                CFG_FULL_LEVEL:  n_cfg.full_level_mv    = i_data[12:0];
                CFG_MID_LEVEL:   n_cfg.mid_level_mv     = i_data[12:0];
                CFG_FULL_PERIOD: n_cfg.full_period_min  = i_data;
                CFG_MID_PERIOD:  n_cfg.mid_period_min   = i_data;
                CFG_CHANGE_LIM:  n_cfg.change_limit_q10 = i_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_level_mv    <= 13'd4000;
            r_cfg.mid_level_mv     <= 13'd3600;
            r_cfg.full_period_min  <= 16'd10;
            r_cfg.mid_period_min   <= 16'd30;
            r_cfg.change_limit_q10 <= 16'd51;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/batp_level.sv]
// voltage window, three-sample average and FULL/MID/LOW classification
// depends on batp_pkg for types, level codes and the divide-by-three helper
module batp_level import batp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in       i_item,
    input  t_cfg      i_cfg,
    input  logic      i_buf_nonempty,
    output t_lvl_stat o_stat,
    output t_lvl_res  o_res
);

    logic [12:0] r_win [3];
    logic [12:0] n_win [3];
    logic [1:0]  r_pos;
    logic [1:0]  n_pos;
    logic [1:0]  r_level;
    logic [1:0]  n_level;
    logic [31:0] r_changes;
    logic [31:0] n_changes;
    logic [31:0] r_low_entry;
    logic [31:0] n_low_entry;
    logic [12:0] r_avg;
    logic [12:0] n_avg;

    logic        sample;
    logic [12:0] cand_win [3];
    logic [14:0] cand_sum;
    logic [14:0] full_thr3;
    logic [14:0] mid_thr3;
    logic [1:0]  cand_level;
    logic        flush;

    assign sample = i_fire && (i_item.mode == MODE_SAMPLE);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cand_win[i] = (r_pos == 2'(i)) ? i_item.battery_mv : r_win[i];
        end
        cand_sum = 15'(cand_win[0]) + 15'(cand_win[1]) + 15'(cand_win[2]);
    end

    // avg >= t is the same as sum >= 3t, so no divide sits in the compare
    assign full_thr3 = {1'b0, i_cfg.full_level_mv, 1'b0} + 15'(i_cfg.full_level_mv);
    assign mid_thr3  = {1'b0, i_cfg.mid_level_mv, 1'b0} + 15'(i_cfg.mid_level_mv);

    always_comb begin
        if (cand_sum >= full_thr3) begin
            cand_level = LVL_FULL;
        end else if (cand_sum >= mid_thr3) begin
            cand_level = LVL_MID;
        end else begin
            cand_level = LVL_LOW;
        end
    end

    always_comb begin
        n_win       = r_win;
        n_pos       = r_pos;
        n_level     = r_level;
        n_changes   = r_changes;
        n_low_entry = r_low_entry;
        n_avg       = r_avg;
        flush       = 1'b0;
        if (sample) begin
            n_win = cand_win;
            n_pos = (r_pos >= 2'd2) ? 2'd0 : r_pos + 2'd1;
            n_avg = div3(cand_sum);
            if (cand_level != r_level) begin
                n_changes = r_changes + 32'd1;
                flush     = (r_level == LVL_LOW) && i_buf_nonempty;
                if (cand_level == LVL_LOW) begin
                    n_low_entry = i_item.time_now;
                end
                n_level = cand_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '{default: '0};
            r_pos       <= '0;
            r_level     <= LVL_MID;
            r_changes   <= '0;
            r_low_entry <= '0;
            r_avg       <= '0;
        end else begin
            r_win       <= n_win;
            r_pos       <= n_pos;
            r_level     <= n_level;
            r_changes   <= n_changes;
            r_low_entry <= n_low_entry;
            r_avg       <= n_avg;
        end
    end

    assign o_stat.level          = r_level;
    assign o_stat.low_entry_time = r_low_entry;

    assign o_res.level         = n_level;
    assign o_res.flush_request = flush;
    assign o_res.filtered_mv   = n_avg;

endmodule

[hdl/batp_policy.sv]
// transmit decision, low-state buffering, send bookkeeping and savings figure
// depends on batp_pkg for types, codes and the savings helper
module batp_policy import batp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in       i_item,
    input  t_cfg      i_cfg,
    input  t_lvl_stat i_stat,
    output t_pol_res  o_res,
    output logic      o_buf_nonempty,
    output logic [6:0] o_savings
);

    logic [31:0]        r_last_time;
    logic [31:0]        n_last_time;
    logic signed [23:0] r_last_val;
    logic signed [23:0] n_last_val;
    logic [BUF_W-1:0]   r_buf;
    logic [BUF_W-1:0]   n_buf;
    logic [31:0]        r_cnt [3];
    logic [31:0]        n_cnt [3];

    logic [31:0]        elapsed;
    logic [31:0]        low_elapsed;
    logic signed [24:0] diff;
    logic [24:0]        diff_abs;
    logic [38:0]        lhs;
    logic [38:0]        rhs;
    logic               last_pos;
    logic               change_hit;
    logic [33:0]        total;
    t_pol_res           res;

    assign elapsed     = i_item.time_now - r_last_time;
    assign low_elapsed = i_item.time_now - i_stat.low_entry_time;

    // relative change: |d| * 1024 > limit * last, only for a positive last value
    assign last_pos   = !r_last_val[23] && (r_last_val != '0);
    assign diff       = 25'(i_item.sensor_reading) - 25'(r_last_val);
    assign diff_abs   = diff[24] ? 25'(-diff) : 25'(diff);
    assign lhs        = {4'd0, diff_abs, 10'd0};
    assign rhs        = 39'(i_cfg.change_limit_q10) * 39'(r_last_val[22:0]);
    assign change_hit = last_pos && (lhs > rhs);

    always_comb begin
        res         = '0;
        n_last_time = r_last_time;
        n_last_val  = r_last_val;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        if (i_fire) begin
            unique case (i_item.mode)
                MODE_CHECK: begin
                    if (i_item.force_req) begin
                        res.transmit = 1'b1;
                    end else if (i_stat.level == LVL_FULL) begin
                        res.transmit = elapsed >= 32'(i_cfg.full_period_min);
                    end else if (i_stat.level == LVL_MID) begin
                        res.transmit = (elapsed >= 32'(i_cfg.mid_period_min)) || change_hit;
                    end else begin
                        if (r_buf < BUF_W'(STORE_DEPTH)) begin
                            res.store_write = 1'b1;
                            res.store_slot  = 8'(r_buf);
                            n_buf           = r_buf + BUF_W'(1);
                        end
                        res.transmit = low_elapsed >= DAY_MINUTES;
                    end
                end
                MODE_DONE: begin
                    n_last_time = i_item.time_now;
                    n_last_val  = i_item.sensor_reading;
                    case (i_stat.level)
                        LVL_FULL: n_cnt[0] = r_cnt[0] + 32'd1;
                        LVL_MID:  n_cnt[1] = r_cnt[1] + 32'd1;
                        LVL_LOW:  n_cnt[2] = r_cnt[2] + 32'd1;
                        default:  n_cnt    = r_cnt;
                    endcase
                    if (i_stat.level != LVL_LOW) begin
                        n_buf = '0;
                    end
                end
                default: begin
                    res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_last_val  <= '0;
            r_buf       <= '0;
            r_cnt       <= '{default: '0};
        end else begin
            r_last_time <= n_last_time;
            r_last_val  <= n_last_val;
            r_buf       <= n_buf;
            r_cnt       <= n_cnt;
        end
    end

    // counters only move when a new result is loaded, so this tracks the held result
    assign total     = 34'(r_cnt[0]) + 34'(r_cnt[1]) + 34'(r_cnt[2]);
    assign o_savings = savings_pct(total);

    assign o_res          = res;
    assign o_buf_nonempty = r_buf != '0;

endmodule

[hdl/battery_aware_transmit_policy_core.sv]
// battery-aware transmit policy, top level: input register, result register, handshakes
// order: input register, then the result register once it is free or drains
// one transaction per cycle unless the output stalls; one result per transaction
// the step is a single pass of logic between the input and result registers
// reset: synchronous, active low; clears handshake state, policy state and loads the
// default configuration; no clearing pass, the block is ready right after reset
module battery_aware_transmit_policy_core import batp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in                  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out                 o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic      r_in_valid;
    logic      n_in_valid;
    t_in       r_in;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out      r_out;
    t_out      n_out;

    logic      accept;
    logic      fire;
    t_cfg      cfg;
    t_lvl_stat lvl_stat;
    t_lvl_res  lvl_res;
    t_pol_res  pol_res;
    logic      buf_nonempty;
    logic [6:0] savings;

    assign o_cfg_ready = 1'b1;

    // the item in the input register moves on when the result register is free or drains
    assign fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    batp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    batp_level u_level (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_item         (r_in),
        .i_cfg          (cfg),
        .i_buf_nonempty (buf_nonempty),
        .o_stat         (lvl_stat),
        .o_res          (lvl_res)
    );

    batp_policy u_policy (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_item         (r_in),
        .i_cfg          (cfg),
        .i_stat         (lvl_stat),
        .o_res          (pol_res),
        .o_buf_nonempty (buf_nonempty),
        .o_savings      (savings)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = fire ? 1'b1 : (r_out_valid && i_stall);
    end

    always_comb begin
        n_out                 = '0;
        n_out.power_level     = lvl_res.level;
        n_out.transmit        = pol_res.transmit;
        n_out.flush_request   = lvl_res.flush_request;
        n_out.store_write     = pol_res.store_write;
        n_out.store_slot      = pol_res.store_slot;
        n_out.filtered_mv     = lvl_res.filtered_mv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;

    always_comb begin
        o_data                 = r_out;
        o_data.savings_percent = savings;
    end

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && o_valid && i_stall))
        else $error("input stalled while the result register could drain");

    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_valid)
        else $error("processed transaction left no result");

    a_store_only_in_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.store_write) |-> (o_data.power_level == LVL_LOW))
        else $error("buffer write reported outside the low state");

    a_flush_leaves_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.flush_request) |-> (o_data.power_level != LVL_LOW))
        else $error("flush request while still in the low state");
`endif

endmodule

[sim/batp_result_check.sv]
// result checker for the battery-aware transmit policy core
// watches the input, result and register channels, predicts each result and compares it
// depends on batp_pkg for the payload, configuration and code types
module batp_result_check import batp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in                  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out                 i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_transmits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   MAX_REPORTS = 10;
    localparam t_cfg RESET_CFG   = '{13'd4000, 13'd3600, 16'd10, 16'd30, 16'd51};

    t_cfg               cfg;
    logic [12:0]        window [3];
    logic [1:0]         window_pos;
    logic [1:0]         level;
    logic [31:0]        last_tx_time;
    logic signed [23:0] last_tx_value;
    logic [31:0]        low_since;
    logic [8:0]         stored;
    logic [31:0]        sends [3];
    logic [31:0]        level_changes;
    t_out               pending_results [$];

    function automatic logic [12:0] window_avg();
        return 13'((int'(window[0]) + int'(window[1]) + int'(window[2])) / 3);
    endfunction

    // total is kept wide so the counters never wrap inside the sum
    function automatic logic [6:0] savings();
        longint total;
        total = longint'(sends[0]) + longint'(sends[1]) + longint'(sends[2]);
        if (total < 144) begin
            return 7'(((144 - total) * 100) / 144);
        end
        return 7'd0;
    endfunction

    // only meaningful against a positive last sent value
    function automatic logic relative_jump(input logic signed [23:0] v);
        longint prev;
        longint d;
        prev = last_tx_value;
        if (prev <= 0) begin
            return 1'b0;
        end
        d = longint'(v) - prev;
        if (d < 0) begin
            d = -d;
        end
        return (d * 1024) > (longint'(cfg.change_limit_q10) * prev);
    endfunction

    function automatic t_out next_policy_result(input t_in it);
        t_out        r;
        logic [31:0] elapsed;
        logic [12:0] avg;
        logic [1:0]  nxt;
        r       = '0;
        elapsed = it.time_now - last_tx_time;
        case (it.mode)
            MODE_SAMPLE: begin
                window[window_pos] = it.battery_mv;
                window_pos = (window_pos == 2'd2) ? 2'd0 : window_pos + 2'd1;
                avg = window_avg();
                if (avg >= cfg.full_level_mv) begin
                    nxt = LVL_FULL;
                end else if (avg >= cfg.mid_level_mv) begin
                    nxt = LVL_MID;
                end else begin
                    nxt = LVL_LOW;
                end
                if (nxt != level) begin
                    level_changes++;
                    if (level == LVL_LOW && stored != 0) begin
                        r.flush_request = 1'b1;
                    end
                    if (nxt == LVL_LOW) begin
                        low_since = it.time_now;
                    end
                    level = nxt;
                end
            end
            MODE_CHECK: begin
                if (it.force_req) begin
                    r.transmit = 1'b1;
                end else if (level == LVL_FULL) begin
                    r.transmit = elapsed >= 32'(cfg.full_period_min);
                end else if (level == LVL_MID) begin
                    r.transmit = (elapsed >= 32'(cfg.mid_period_min))
                                 || relative_jump(it.sensor_reading);
                end else begin
                    if (stored < STORE_DEPTH) begin
                        r.store_write = 1'b1;
                        r.store_slot  = stored[7:0];
                        stored++;
                    end
                    r.transmit = (it.time_now - low_since) >= DAY_MINUTES;
                end
            end
            MODE_DONE: begin
                last_tx_time  = it.time_now;
                last_tx_value = it.sensor_reading;
                sends[level]++;
                // the buffer only empties once a send happens outside low
                if (level != LVL_LOW) begin
                    stored = '0;
                end
            end
            default: ;
        endcase
        r.power_level     = level;
        r.filtered_mv     = window_avg();
        r.savings_percent = savings();
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            if (o_errors < MAX_REPORTS) begin
                $display("result %0d: %s expected %0d, got %0d", o_checked, name, want, got);
            end
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            cfg           = RESET_CFG;
            window        = '{default: '0};
            window_pos    = '0;
            level         = LVL_MID;
            last_tx_time  = '0;
            last_tx_value = '0;
            low_since     = '0;
            stored        = '0;
            sends         = '{default: '0};
            level_changes = '0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    if (o_errors < MAX_REPORTS) begin
                        $display("result with no transaction outstanding: %p", i_out_data);
                    end
                    o_errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("power_level", want.power_level, i_out_data.power_level);
                    check_field("transmit", want.transmit, i_out_data.transmit);
                    check_field("flush_request", want.flush_request,
                                i_out_data.flush_request);
                    check_field("store_write", want.store_write, i_out_data.store_write);
                    check_field("store_slot", want.store_slot, i_out_data.store_slot);
                    check_field("filtered_mv", want.filtered_mv, i_out_data.filtered_mv);
                    check_field("savings_percent", want.savings_percent,
                                i_out_data.savings_percent);
                    if (want.transmit) begin
                        o_transmits++;
                    end
                    o_checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FULL_LEVEL:  cfg.full_level_mv    = i_cfg_data[12:0];
                    CFG_MID_LEVEL:   cfg.mid_level_mv     = i_cfg_data[12:0];
                    CFG_FULL_PERIOD: cfg.full_period_min  = i_cfg_data;
                    CFG_MID_PERIOD:  cfg.mid_period_min   = i_cfg_data;
                    CFG_CHANGE_LIM:  cfg.change_limit_q10 = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(next_policy_result(i_in_data));
            end
        end
        o_pending = pending_results.size();
    end

endmodule

[sim/battery_aware_transmit_policy_core_test.sv]
// testbench top for the battery-aware transmit policy core: clock, reset, stimulus, verdict
// drives directed and random transactions under several register settings and idle patterns
// depends on batp_pkg, the core and batp_result_check
module battery_aware_transmit_policy_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import batp_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 i_stall     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    t_in                  i_data      = '0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data  = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic                 o_cfg_ready;
    t_out                 o_data;

    int errors;
    int pending;
    int checked;
    int transmits;

    int          send_idle_pct  = 15;
    int          recv_idle_pct  = 65;
    int          sent           = 0;
    int          settings_used  = 0;
    logic [31:0] now_min        = '0;
    int          data_centre    = 1000;
    t_cfg        policy_cfg     = '{13'd4000, 13'd3600, 16'd10, 16'd30, 16'd51};
    t_in         directed [$];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    battery_aware_transmit_policy_core i_dut (.*);

    batp_result_check u_results (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_data  (o_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_transmits (transmits)
    );

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    function automatic t_in ev(input logic [1:0] m, input logic [31:0] t,
                               input logic [12:0] mv, input logic [23:0] d, input logic f);
        t_in it;
        it.mode           = m;
        it.time_now       = t;
        it.battery_mv     = mv;
        it.sensor_reading = d;
        it.force_req      = f;
        return it;
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.full_level_mv    = 13'($urandom_range(3000, 5000));
        c.mid_level_mv     = 13'($urandom_range(2500, c.full_level_mv));
        c.full_period_min  = 16'($urandom_range(0, 120));
        c.mid_period_min   = 16'($urandom_range(0, 240));
        c.change_limit_q10 = 16'($urandom_range(0, 300));
        return c;
    endfunction

    // mostly samples near the thresholds and readings near the last sent value
    function automatic t_in random_event(input int check_weight);
        t_in it;
        int  r;
        int  mv;
        int  span;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            now_min += 32'($urandom_range(1000, 3000));
        end else if (r < 6) begin
            now_min = $urandom;
        end else begin
            now_min += 32'($urandom_range(0, 25));
        end
        it.time_now       = now_min;
        it.force_req      = ($urandom_range(0, 99) < 8);
        it.battery_mv     = 13'($urandom);
        it.sensor_reading = 24'($urandom);
        r = $urandom_range(0, 99);
        if (r < 4) begin
            it.mode = MODE_UNUSED;
        end else if (r < 4 + check_weight) begin
            it.mode = MODE_CHECK;
        end else if (r < 4 + check_weight + (96 - check_weight) * 3 / 5) begin
            it.mode = MODE_SAMPLE;
        end else begin
            it.mode = MODE_DONE;
        end
        if ($urandom_range(0, 9) != 0) begin
            mv = $urandom_range(0, 1) ? int'(policy_cfg.full_level_mv)
                                      : int'(policy_cfg.mid_level_mv);
            mv = mv + int'($urandom_range(0, 600)) - 300;
            if (mv < 0) begin
                mv = 0;
            end else if (mv > 8190) begin
                mv = 8190;
            end
            it.battery_mv = 13'(mv);
            span = data_centre / 8 + 1;
            it.sensor_reading = 24'(data_centre + int'($urandom_range(0, 2 * span)) - span);
        end
        if ($urandom_range(0, 49) == 0) begin
            data_centre = int'($urandom_range(1, 4000000));
        end
        if (it.mode == MODE_DONE && !it.sensor_reading[23] && it.sensor_reading != 0) begin
            data_centre = int'($signed(it.sensor_reading));
        end
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send(input t_in it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_config(input t_cfg c);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [15:0]          val [5];
        idx = '{CFG_FULL_LEVEL, CFG_MID_LEVEL, CFG_FULL_PERIOD, CFG_MID_PERIOD,
                CFG_CHANGE_LIM};
        val = '{16'(c.full_level_mv), 16'(c.mid_level_mv), c.full_period_min,
                c.mid_period_min, c.change_limit_q10};
        for (int k = 0; k < 5; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        policy_cfg = c;
        settings_used++;
    endtask

    task automatic run_phase(input t_cfg c, input int items, input int check_weight);
        write_config(c);
        repeat (items) send(random_event(check_weight));
        settle();
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: change test, intervals, day rule in low, buffering and flush
        directed = '{
            ev(MODE_UNUSED, 32'hFFFF_FFFF, 13'h1FFF, 24'h7F_FFFF, 1'b1),
            ev(MODE_CHECK,  32'd5,    13'd0,    24'd0,        1'b0),
            ev(MODE_DONE,   32'd5,    13'd0,    24'd1000,     1'b0),
            ev(MODE_CHECK,  32'd10,   13'd0,    24'd1049,     1'b0),
            ev(MODE_CHECK,  32'd10,   13'd0,    24'd1050,     1'b0),
            ev(MODE_CHECK,  32'd12,   13'd0,    24'd951,      1'b0),
            ev(MODE_CHECK,  32'd12,   13'd0,    24'd950,      1'b0),
            ev(MODE_CHECK,  32'd35,   13'd0,    24'd1000,     1'b0),
            ev(MODE_CHECK,  32'd6,    13'd0,    24'd1000,     1'b1),
            ev(MODE_SAMPLE, 32'd40,   13'h1FFF, 24'd0,        1'b0),
            ev(MODE_SAMPLE, 32'd40,   13'h1FFF, 24'd0,        1'b0),
            ev(MODE_SAMPLE, 32'd40,   13'h1FFF, 24'd0,        1'b0),
            ev(MODE_CHECK,  32'd50,   13'd0,    24'd0,        1'b0),
            ev(MODE_SAMPLE, 32'd100,  13'd0,    24'd0,        1'b0),
            ev(MODE_SAMPLE, 32'd100,  13'd0,    24'd0,        1'b0),
            ev(MODE_SAMPLE, 32'd100,  13'd0,    24'd0,        1'b0),
            ev(MODE_CHECK,  32'd200,  13'd0,    24'hFF_FFFB,  1'b0),
            ev(MODE_CHECK,  32'd300,  13'd0,    24'd0,        1'b1),
            ev(MODE_CHECK,  32'd1540, 13'd0,    24'd0,        1'b0),
            ev(MODE_DONE,   32'd1540, 13'd0,    24'h80_0000,  1'b0),
            ev(MODE_SAMPLE, 32'd1600, 13'h1FFF, 24'd0,        1'b0),
            ev(MODE_SAMPLE, 32'd1600, 13'h1FFF, 24'd0,        1'b0),
            ev(MODE_DONE,   32'hFFFF_FFFF, 13'd0, 24'h7F_FFFF, 1'b0),
            ev(MODE_CHECK,  32'd4,    13'd0,    24'd0,        1'b0),
            ev(MODE_UNUSED, 32'd0,    13'd0,    24'd0,        1'b0)
        };
        foreach (directed[k]) begin
            send(directed[k]);
        end
        settle();

        run_phase('{13'd4000, 13'd3600, 16'd10, 16'd30, 16'd51}, 250, 35);
        run_phase('0, 250, 35);

        send_idle_pct = 65;
        recv_idle_pct = 15;
        run_phase(random_cfg(), 250, 35);
        // stays in low long enough to fill the store
        run_phase('{13'h1FFF, 13'h1FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 400, 75);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // full threshold below mid: mid can never be chosen
        run_phase('{13'd3000, 13'd4200, 16'd5, 16'd60, 16'd1024}, 200, 35);
        now_min = 32'hFFFF_FE00;
        run_phase(random_cfg(), 200, 35);

        $display("%0d transactions sent under %0d register settings plus reset values",
                 sent, settings_used);
        $display("%0d results checked, %0d of them transmit decisions", checked, transmits);
        if (errors == 0 && pending == 0) begin
            $display("battery_aware_transmit_policy_core_test: done, clean");
        end else begin
            $display("battery_aware_transmit_policy_core_test: done, errors");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("battery_aware_transmit_policy_core_test: done, errors");
        $finish;
    end

endmodule
